FILE: hw/rtl/timestamp_ordered_frame_queue_top_defines.svh
// Assertion macros for the timestamp ordered frame queue.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef TIMESTAMP_ORDERED_FRAME_QUEUE_TOP_DEFINES_SVH
`define TIMESTAMP_ORDERED_FRAME_QUEUE_TOP_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define TOFQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tofq assertion failed");

// Check the consequent in the cycle after the antecedent.
`define TOFQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tofq assertion failed");

`endif

FILE: hw/rtl/tofq_pkg.sv
`timescale 1ns / 1ps

package tofq_pkg;

    localparam int TOFQ_DEPTH = 16;
    localparam logic [4:0] MAX_FILL_RESET = 5'd16;

    // action codes
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_GET   = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_PUT_DECIDE,
        ST_UP_RD,
        ST_UP_WR,
        ST_PUT_WR,
        ST_GET_CHK,
        ST_DN_RD,
        ST_DN_WR,
        ST_FL_HOLD,
        ST_FL_EMIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [63:0] key;
        logic [15:0] handle;
        logic        eos;
    } t_entry;

    typedef struct packed {
        logic        out_valid;
        logic [15:0] out_handle;
        logic        out_eos;
        logic        released_valid;
        logic [15:0] released_handle;
        logic        overflow;
    } t_flags;

    typedef struct packed {
        t_flags      flags;
        logic [4:0]  occupancy;
        logic        writable;
        logic        head_valid;
        logic [63:0] head_pts;
        logic        last;
    } t_result;

endpackage

FILE: hw/rtl/timestamp_ordered_frame_queue_top.sv
// Put: decode, scan the sorted table, decide, shift later entries up, write the new entry;
// a put that matches a stored timestamp replaces that entry in place after the scan.
// Get: read and check the head, then shift the remaining entries down (no read if empty).
// Flush: read and hold the head, then one result per cycle while the consumer takes them.
// One request at a time; each table step is one read or write of the single table port.
// Reset clears the entry count and state machine and sets max_fill to 16; no table clear.
`timescale 1ns / 1ps
`include "timestamp_ordered_frame_queue_top_defines.svh"

module timestamp_ordered_frame_queue_top
    import tofq_pkg::*;
#(
    parameter int DEPTH = TOFQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    // request channel
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_frame_pts,
    input  logic [15:0] i_new_handle,
    input  logic        i_new_eos,
    input  logic [63:0] i_render_time,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_out_valid,
    output logic [15:0] o_out_handle,
    output logic        o_out_eos,
    output logic        o_released_valid,
    output logic [15:0] o_released_handle,
    output logic        o_overflow,
    output logic [4:0]  o_occupancy,
    output logic        o_writable,
    output logic        o_head_valid,
    output logic [63:0] o_head_pts,
    output logic        o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ONE = CW'(1);

    // Table memory: single write port, registered read.
    t_entry r_table [DEPTH];
    t_entry r_rd_data;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;

    // Sequencer state.
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [63:0]   r_head_key, n_head_key;
    logic [15:0]   r_hold, n_hold;
    t_flags        r_flags, n_flags;
    logic [4:0]    r_max_fill;

    // Captured request.
    logic [1:0]    r_action;
    logic [63:0]   r_pts;
    logic [15:0]   r_handle;
    logic          r_eos;
    logic [63:0]   r_rt;

    // Output register.
    logic          r_res_valid;
    t_result       r_res;

    logic          req_fire;
    logic          emit_ok;
    logic          emit;
    logic [CW-1:0] emit_count;
    logic [63:0]   emit_head;
    t_flags        emit_flags;
    logic          emit_last;
    logic          emit_full;
    logic          cur_full;
    logic          key_eq;
    logic          key_gt;
    logic          get_due;
    t_result       n_res;

    assign o_cfg_ready = 1'b1;
    assign o_req_ready = (r_state == ST_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign emit_ok     = !r_res_valid || i_res_ready;

    // Compare unit for the put scan: stored key against the put timestamp.
    assign key_eq = (r_rd_data.key == r_pts);
    assign key_gt = ($signed(r_rd_data.key) > $signed(r_pts));
    // Get condition: head due, or sole remaining frame marks end of stream.
    assign get_due = ($signed(r_rd_data.key) <= $signed(r_rt)) ||
                     ((r_count == ONE) && r_rd_data.eos);

    assign cur_full  = (32'(r_count) >= 32'(r_max_fill)) || (32'(r_count) >= DEPTH);
    assign emit_full = (32'(emit_count) >= 32'(r_max_fill)) || (32'(emit_count) >= DEPTH);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fill <= MAX_FILL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_fill <= i_cfg_data;
        end
    end

    // Capture the request on accept.
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_action <= i_action;
            r_pts    <= i_frame_pts;
            r_handle <= i_new_handle;
            r_eos    <= i_new_eos;
            r_rt     <= i_render_time;
        end
    end

    // Table port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_head_key <= n_head_key;
        r_hold     <= n_hold;
        r_flags    <= n_flags;
    end

    // Next state and table control.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_head_key = r_head_key;
        n_hold     = r_hold;
        n_flags    = r_flags;
        rd_en      = 1'b0;
        rd_addr    = r_idx[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_idx[AW-1:0];
        wr_data    = r_rd_data;
        emit       = 1'b0;
        emit_count = r_count;
        emit_head  = r_head_key;
        emit_flags = r_flags;
        emit_last  = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_state = ST_DECODE;
                end
            end

            ST_DECODE: begin
                n_flags = '0;
                n_idx   = '0;
                case (r_action)
                    ACT_PUT: begin
                        if (r_count == '0) begin
                            n_pos   = '0;
                            n_state = ST_PUT_DECIDE;
                        end else begin
                            n_state = ST_SCAN_RD;
                        end
                    end
                    ACT_GET: begin
                        if (r_count == '0) begin
                            n_state = ST_EMIT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = ST_GET_CHK;
                        end
                    end
                    ACT_FLUSH: begin
                        if (r_count == '0) begin
                            n_state = ST_EMIT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = ST_FL_HOLD;
                        end
                    end
                    default: begin
                        n_state = ST_EMIT;
                    end
                endcase
            end

            // Walk the sorted table for a matching or later timestamp.
            ST_SCAN_RD: begin
                rd_en   = 1'b1;
                n_state = ST_SCAN_CMP;
            end

            ST_SCAN_CMP: begin
                if (key_eq) begin
                    // replace in place, release the old handle
                    wr_en                   = 1'b1;
                    wr_data.key             = r_pts;
                    wr_data.handle          = r_handle;
                    wr_data.eos             = r_eos;
                    n_flags.released_valid  = 1'b1;
                    n_flags.released_handle = r_rd_data.handle;
                    n_state                 = ST_EMIT;
                end else if (key_gt) begin
                    n_pos   = r_idx;
                    n_state = ST_PUT_DECIDE;
                end else if (CW'(r_idx + ONE) == r_count) begin
                    n_pos   = r_count;
                    n_state = ST_PUT_DECIDE;
                end else begin
                    n_idx   = CW'(r_idx + ONE);
                    n_state = ST_SCAN_RD;
                end
            end

            ST_PUT_DECIDE: begin
                if (cur_full) begin
                    // reject: hand the new frame straight back
                    n_flags.released_valid  = 1'b1;
                    n_flags.released_handle = r_handle;
                    n_flags.overflow        = 1'b1;
                    n_state                 = ST_EMIT;
                end else if (r_pos == r_count) begin
                    n_state = ST_PUT_WR;
                end else begin
                    n_idx   = r_count;
                    n_state = ST_UP_RD;
                end
            end

            // Open a slot at the insert position, moving the tail up one entry.
            ST_UP_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_idx - ONE);
                n_state = ST_UP_WR;
            end

            ST_UP_WR: begin
                wr_en = 1'b1;
                if (CW'(r_idx - ONE) == r_pos) begin
                    n_state = ST_PUT_WR;
                end else begin
                    n_idx   = CW'(r_idx - ONE);
                    n_state = ST_UP_RD;
                end
            end

            ST_PUT_WR: begin
                wr_en          = 1'b1;
                wr_addr        = r_pos[AW-1:0];
                wr_data.key    = r_pts;
                wr_data.handle = r_handle;
                wr_data.eos    = r_eos;
                n_count        = CW'(r_count + ONE);
                if (r_pos == '0) begin
                    n_head_key = r_pts;
                end
                n_state = ST_EMIT;
            end

            ST_GET_CHK: begin
                if (get_due) begin
                    n_flags.out_valid  = 1'b1;
                    n_flags.out_handle = r_rd_data.handle;
                    n_flags.out_eos    = r_rd_data.eos;
                    if (r_count == ONE) begin
                        n_count = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_idx   = ONE;
                        n_state = ST_DN_RD;
                    end
                end else begin
                    n_state = ST_EMIT;
                end
            end

            // Drop the head, moving the rest down one entry.
            ST_DN_RD: begin
                rd_en   = 1'b1;
                n_state = ST_DN_WR;
            end

            ST_DN_WR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_idx - ONE);
                if (r_idx == ONE) begin
                    n_head_key = r_rd_data.key;
                end
                if (CW'(r_idx + ONE) == r_count) begin
                    n_count = CW'(r_count - ONE);
                    n_state = ST_EMIT;
                end else begin
                    n_idx   = CW'(r_idx + ONE);
                    n_state = ST_DN_RD;
                end
            end

            // Flush: hold the handle being released, prefetch the next head.
            ST_FL_HOLD: begin
                n_hold = r_rd_data.handle;
                if (r_count != ONE) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx + ONE);
                end
                n_state = ST_FL_EMIT;
            end

            ST_FL_EMIT: begin
                emit_count                 = CW'(r_count - ONE);
                emit_head                  = r_rd_data.key;
                emit_flags                 = '0;
                emit_flags.released_valid  = 1'b1;
                emit_flags.released_handle = r_hold;
                emit_last                  = (r_count == ONE);
                if (emit_ok) begin
                    emit       = 1'b1;
                    n_count    = CW'(r_count - ONE);
                    n_head_key = r_rd_data.key;
                    if (r_count == ONE) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_hold = r_rd_data.handle;
                        n_idx  = CW'(r_idx + ONE);
                        if (CW'(r_count - ONE) != ONE) begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(r_idx + CW'(2));
                        end
                    end
                end
            end

            ST_EMIT: begin
                if (emit_ok) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Assemble the result with status taken after this result's update.
    always_comb begin
        n_res.flags      = emit_flags;
        n_res.occupancy  = 5'(emit_count);
        n_res.writable   = !emit_full;
        n_res.head_valid = (emit_count != '0);
        n_res.head_pts   = (emit_count != '0) ? emit_head : 64'd0;
        n_res.last       = emit_last;
    end

    // Output register: hold until taken, load a new result as the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_out_valid       = r_res.flags.out_valid;
    assign o_out_handle      = r_res.flags.out_handle;
    assign o_out_eos         = r_res.flags.out_eos;
    assign o_released_valid  = r_res.flags.released_valid;
    assign o_released_handle = r_res.flags.released_handle;
    assign o_overflow        = r_res.flags.overflow;
    assign o_occupancy       = r_res.occupancy;
    assign o_writable        = r_res.writable;
    assign o_head_valid      = r_res.head_valid;
    assign o_head_pts        = r_res.head_pts;
    assign o_last            = r_res.last;

    // Entry count never passes the table depth.
    `TOFQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    // An accepted request always goes to decode next.
    `TOFQ_ASSERT_NEXT(a_req_decode, req_fire, r_state == ST_DECODE)
    // Only a flush produces a result that is not the last of its run.
    `TOFQ_ASSERT_NOW(a_run_flush, o_res_valid && !o_last, o_released_valid && !o_out_valid)
    // A rejected put reports no room and releases its handle.
    `TOFQ_ASSERT_NOW(a_overflow, o_res_valid && o_overflow, !o_writable && o_released_valid)

endmodule

FILE: verif/timestamp_ordered_frame_queue_top_test.sv
`timescale 1ns / 1ps

module timestamp_ordered_frame_queue_top_test;
    import tofq_pkg::*;

    localparam logic [63:0] PTS_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] PTS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    // worst put latency plus margin; used for the quiet tail at the end
    localparam int DRAIN_CYCLES = 4 * TOFQ_DEPTH + 8;
    // slowest gap between two handshakes is one full put plus a sender gap
    // plus a consumer stall; allow many times that
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [1:0]  action;
        logic [63:0] pts;
        logic [15:0] handle;
        logic        eos;
        logic [63:0] render;
    } t_frame_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;
    logic        i_req_valid = 1'b0;
    logic        o_req_ready;
    logic [1:0]  i_action = ACT_PUT;
    logic [63:0] i_frame_pts = '0;
    logic [15:0] i_new_handle = '0;
    logic        i_new_eos = 1'b0;
    logic [63:0] i_render_time = '0;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    logic        o_out_valid;
    logic [15:0] o_out_handle;
    logic        o_out_eos;
    logic        o_released_valid;
    logic [15:0] o_released_handle;
    logic        o_overflow;
    logic [4:0]  o_occupancy;
    logic        o_writable;
    logic        o_head_valid;
    logic [63:0] o_head_pts;
    logic        o_last;

    timestamp_ordered_frame_queue_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_req_valid      (i_req_valid),
        .o_req_ready      (o_req_ready),
        .i_action         (i_action),
        .i_frame_pts      (i_frame_pts),
        .i_new_handle     (i_new_handle),
        .i_new_eos        (i_new_eos),
        .i_render_time    (i_render_time),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_out_valid      (o_out_valid),
        .o_out_handle     (o_out_handle),
        .o_out_eos        (o_out_eos),
        .o_released_valid (o_released_valid),
        .o_released_handle(o_released_handle),
        .o_overflow       (o_overflow),
        .o_occupancy      (o_occupancy),
        .o_writable       (o_writable),
        .o_head_valid     (o_head_valid),
        .o_head_pts       (o_head_pts),
        .o_last           (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the queue: sorted frames, earliest timestamp first.
    // ------------------------------------------------------------------
    logic signed [63:0] shadow_key [TOFQ_DEPTH];
    logic [15:0]        shadow_handle [TOFQ_DEPTH];
    logic               shadow_eos [TOFQ_DEPTH];
    int                 shadow_count = 0;
    logic [4:0]         fill_limit = MAX_FILL_RESET;

    t_result    frame_results_due[$];
    t_frame_req request_backlog[$];

    // bookkeeping shared between the stimulus, driver and monitor
    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_cfg_done = 0;
    int  n_results = 0;
    int  n_puts = 0;
    int  n_gets = 0;
    int  n_flushes = 0;
    int  n_replaced = 0;
    int  n_rejected = 0;
    int  n_returned = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    logic req_accept = 1'b0;
    logic idle_on = 1'b0;
    logic signed [63:0] stream_pts = '0;

    function automatic logic queue_full();
        return (shadow_count >= fill_limit) || (shadow_count >= TOFQ_DEPTH);
    endfunction

    // Record one expected result; status fields reflect the table after the update.
    function automatic void expect_status(logic ov, logic [15:0] oh, logic oe, logic rv,
                                          logic [15:0] rh, logic ovf, logic lst);
        t_result r;
        r.flags.out_valid       = ov;
        r.flags.out_handle      = ov ? oh : 16'd0;
        r.flags.out_eos         = ov ? oe : 1'b0;
        r.flags.released_valid  = rv;
        r.flags.released_handle = rv ? rh : 16'd0;
        r.flags.overflow        = ovf;
        r.occupancy             = shadow_count[4:0];
        r.writable              = !queue_full();
        r.head_valid            = shadow_count > 0;
        r.head_pts              = (shadow_count > 0) ? shadow_key[0] : 64'd0;
        r.last                  = lst;
        frame_results_due.push_back(r);
    endfunction

    function automatic void pop_earliest();
        for (int i = 1; i < shadow_count; i++) begin
            shadow_key[i - 1]    = shadow_key[i];
            shadow_handle[i - 1] = shadow_handle[i];
            shadow_eos[i - 1]    = shadow_eos[i];
        end
        shadow_count--;
    endfunction

    // Advance the shadow queue by one request and queue the results it must produce.
    function automatic void apply_frame_request(t_frame_req q);
        int          pos;
        int          hit;
        logic [15:0] h;
        logic        e;
        hit = -1;
        case (q.action)
            ACT_PUT: begin
                n_puts++;
                for (int i = 0; i < shadow_count; i++) begin
                    if (hit < 0 && shadow_key[i] == $signed(q.pts)) hit = i;
                end
                if (hit >= 0) begin
                    // same timestamp: swap in the new frame, release the old one
                    h = shadow_handle[hit];
                    shadow_handle[hit] = q.handle;
                    shadow_eos[hit]    = q.eos;
                    n_replaced++;
                    expect_status(1'b0, '0, 1'b0, 1'b1, h, 1'b0, 1'b1);
                end else if (queue_full()) begin
                    n_rejected++;
                    expect_status(1'b0, '0, 1'b0, 1'b1, q.handle, 1'b1, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < shadow_count && shadow_key[pos] <= $signed(q.pts)) pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_key[i]    = shadow_key[i - 1];
                        shadow_handle[i] = shadow_handle[i - 1];
                        shadow_eos[i]    = shadow_eos[i - 1];
                    end
                    shadow_key[pos]    = q.pts;
                    shadow_handle[pos] = q.handle;
                    shadow_eos[pos]    = q.eos;
                    shadow_count++;
                    expect_status(1'b0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ACT_GET: begin
                n_gets++;
                if (shadow_count > 0 && (shadow_key[0] <= $signed(q.render) ||
                                         (shadow_count == 1 && shadow_eos[0]))) begin
                    h = shadow_handle[0];
                    e = shadow_eos[0];
                    pop_earliest();
                    n_returned++;
                    expect_status(1'b1, h, e, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    expect_status(1'b0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ACT_FLUSH: begin
                n_flushes++;
                if (shadow_count == 0) begin
                    expect_status(1'b0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                end
                while (shadow_count > 0) begin
                    h = shadow_handle[0];
                    pop_earliest();
                    expect_status(1'b0, '0, 1'b0, 1'b1, h, 1'b0, shadow_count == 0);
                end
            end
            default: begin
                expect_status(1'b0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic string show_result(t_result r);
        return $sformatf({"out=%0b/%h/%0b rel=%0b/%h ovf=%0b occ=%0d wr=%0b head=%0b/%h",
                          " last=%0b"},
                         r.flags.out_valid, r.flags.out_handle, r.flags.out_eos,
                         r.flags.released_valid, r.flags.released_handle, r.flags.overflow,
                         r.occupancy, r.writable, r.head_valid, r.head_pts, r.last);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge, predict, check.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result     want;
        t_result     got;
        logic [10:0] diff;
        t_frame_req  q;
        if (!i_rst_n) begin
            shadow_count = 0;
            fill_limit   = MAX_FILL_RESET;
            req_accept  <= 1'b0;
        end else begin
            quiet_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                fill_limit = i_cfg_data;
                n_cfg_done++;
                quiet_cycles = 0;
            end
            // predict before checking so a same-edge result still finds its entry
            if (i_req_valid && o_req_ready) begin
                q.action = i_action;
                q.pts    = i_frame_pts;
                q.handle = i_new_handle;
                q.eos    = i_new_eos;
                q.render = i_render_time;
                apply_frame_request(q);
                n_accepted++;
                quiet_cycles = 0;
            end
            req_accept <= i_req_valid && o_req_ready;
            if (o_res_valid && i_res_ready) begin
                quiet_cycles = 0;
                got.flags.out_valid       = o_out_valid;
                got.flags.out_handle      = o_out_handle;
                got.flags.out_eos         = o_out_eos;
                got.flags.released_valid  = o_released_valid;
                got.flags.released_handle = o_released_handle;
                got.flags.overflow        = o_overflow;
                got.occupancy             = o_occupancy;
                got.writable              = o_writable;
                got.head_valid            = o_head_valid;
                got.head_pts              = o_head_pts;
                got.last                  = o_last;
                if (frame_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] result with nothing outstanding: %s",
                                 $realtime, show_result(got));
                    end
                end else begin
                    want = frame_results_due.pop_front();
                    diff = {got.flags.out_valid       !== want.flags.out_valid,
                            got.flags.out_handle      !== want.flags.out_handle,
                            got.flags.out_eos         !== want.flags.out_eos,
                            got.flags.released_valid  !== want.flags.released_valid,
                            got.flags.released_handle !== want.flags.released_handle,
                            got.flags.overflow        !== want.flags.overflow,
                            got.occupancy             !== want.occupancy,
                            got.writable              !== want.writable,
                            got.head_valid            !== want.head_valid,
                            got.head_pts              !== want.head_pts,
                            got.last                  !== want.last};
                    if (diff != '0) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d mismatch, field mask %b",
                                     $realtime, n_results, diff);
                            $display("    expected %s", show_result(want));
                            $display("    actual   %s", show_result(got));
                        end
                    end
                end
                n_results++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver: pop the backlog, hold each request until taken,
    // then optionally sit idle for a burst.
    // ------------------------------------------------------------------
    int req_gap_left = 0;

    always @(negedge i_clk) begin
        t_frame_req q;
        if (i_rst_n) begin
            if (i_req_valid && !req_accept) begin
                // hold: request still waiting for ready
            end else if (req_gap_left > 0) begin
                req_gap_left--;
                i_req_valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
                q = request_backlog.pop_front();
                i_action      <= q.action;
                i_frame_pts   <= q.pts;
                i_new_handle  <= q.handle;
                i_new_eos     <= q.eos;
                i_render_time <= q.render;
                i_req_valid   <= 1'b1;
                if (idle_on && $urandom_range(0, 2) == 0) req_gap_left = $urandom_range(1, 19);
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // Result consumer: ready by default, stalls in random bursts.
    int res_stall_left = 0;

    always @(negedge i_clk) begin
        if (res_stall_left > 0) begin
            res_stall_left--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) res_stall_left = $urandom_range(1, 19);
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    initial begin
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("no handshake for %0d cycles, %0d results still outstanding",
                 WATCHDOG_LIMIT, frame_results_due.size());
        $display("timestamp_ordered_frame_queue_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_request(logic [1:0] act, logic [63:0] pts,
                                          logic [15:0] handle, logic eos,
                                          logic [63:0] render);
        t_frame_req q;
        q.action = act;
        q.pts    = pts;
        q.handle = handle;
        q.eos    = eos;
        q.render = render;
        request_backlog.push_back(q);
        n_queued++;
    endfunction

    // Wait until every request is taken and every result has come back.
    task automatic drain_queue();
        do @(negedge i_clk);
        while (n_accepted != n_queued || frame_results_due.size() != 0);
    endtask

    // Write max_fill; only called while the block is idle.
    task automatic write_fill_limit(input logic [4:0] value);
        int target;
        target = n_cfg_done + 1;
        @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk);
        while (n_cfg_done != target);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly a rising stream of timestamps with some late, repeated and
    // arbitrary ones; render times trail the stream so gets hit and miss.
    task automatic queue_random_requests(input int count, input int put_pct,
                                         input int flush_pct);
        int          roll;
        int          n;
        logic [1:0]  act;
        logic [63:0] pts;
        logic [63:0] render;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            stream_pts = stream_pts + $urandom_range(1, 8);
            case ($urandom_range(0, 9))
                0:       pts = {$urandom, $urandom};
                1:       pts = $urandom_range(0, 1) ? PTS_MIN : PTS_MAX;
                2, 3, 4: pts = stream_pts - $urandom_range(0, 24);
                default: pts = stream_pts;
            endcase
            case ($urandom_range(0, 9))
                0:       render = {$urandom, $urandom};
                1:       render = $urandom_range(0, 1) ? PTS_MIN : PTS_MAX;
                default: render = stream_pts - $urandom_range(0, 40);
            endcase
            if (roll < flush_pct) act = ACT_FLUSH;
            else if (roll < flush_pct + put_pct) act = ACT_PUT;
            else act = ACT_GET;
            queue_request(act, pts, 16'($urandom), 1'($urandom_range(0, 1)), render);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int fill_plan [7];
        int size_plan [7];
        int put_plan  [7];
        fill_plan = '{16, 1, 7, 16, 3, 12, 16};
        size_plan = '{30, 25, 30, 35, 25, 30, 35};
        put_plan  = '{65, 50, 50, 70, 45, 55, 60};

        // hold reset, then release it on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset max_fill: empty get and flush, extreme
        // timestamps, duplicate replacement, due and not-due gets, the lone
        // end-of-stream frame and a lone frame without it.
        queue_request(ACT_GET,   '0,       16'h0000, 1'b0, PTS_MAX);
        queue_request(ACT_FLUSH, '0,       16'h0000, 1'b0, '0);
        queue_request(ACT_PUT,   PTS_MIN,  16'hFFFF, 1'b0, '0);
        queue_request(ACT_PUT,   PTS_MAX,  16'h0000, 1'b1, '0);
        queue_request(ACT_PUT,   64'd0,    16'h1234, 1'b0, '0);
        queue_request(ACT_PUT,   64'd0,    16'hABCD, 1'b1, '0);
        queue_request(ACT_PUT,   '1,       16'h5555, 1'b0, '0);
        queue_request(ACT_GET,   '0,       16'h0000, 1'b0, PTS_MIN);
        queue_request(ACT_GET,   '0,       16'h0000, 1'b0, -64'sd2);
        queue_request(ACT_GET,   '0,       16'h0000, 1'b0, PTS_MAX);
        queue_request(ACT_GET,   '0,       16'h0000, 1'b0, PTS_MIN);
        queue_request(ACT_FLUSH, '0,       16'h0000, 1'b0, '0);
        queue_request(ACT_PUT,   64'd100,  16'hAAAA, 1'b1, '0);
        queue_request(ACT_GET,   '0,       16'h0000, 1'b0, PTS_MIN);
        queue_request(ACT_PUT,   64'd200,  16'h00FF, 1'b0, '0);
        queue_request(ACT_GET,   '0,       16'h0000, 1'b0, PTS_MIN);
        queue_request(ACT_FLUSH, '0,       16'h0000, 1'b0, '0);
        drain_queue();

        // small capacity: fill, reject, replace while full, then flush
        write_fill_limit(5'd2);
        queue_request(ACT_PUT,   64'd10,   16'h0101, 1'b0, '0);
        queue_request(ACT_PUT,   -64'sd10, 16'h0202, 1'b1, '0);
        queue_request(ACT_PUT,   64'd5,    16'h0303, 1'b0, '0);
        queue_request(ACT_PUT,   64'd10,   16'h0404, 1'b1, '0);
        queue_request(ACT_FLUSH, '0,       16'h0000, 1'b0, '0);
        drain_queue();

        // Random phases across capacities; the table carries over between
        // phases, so shrinking max_fill below the held count is exercised too.
        for (int p = 0; p < 7; p++) begin
            write_fill_limit(5'(fill_plan[p]));
            case (p % 3)
                0: stream_pts = {$urandom, $urandom};
                1: stream_pts = -64'sd120;
                default: stream_pts = PTS_MAX - 64'd150;
            endcase
            // the last phase runs with no idling on either side
            idle_on = (p != 6);
            queue_random_requests(size_plan[p], put_plan[p], 8);
            drain_queue();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests (%0d put, %0d get, %0d flush) over %0d max_fill writes",
                 n_accepted, n_puts, n_gets, n_flushes, n_cfg_done);
        $display("checked %0d results: %0d frames returned, %0d replaced, %0d rejected full",
                 n_results, n_returned, n_replaced, n_rejected);
        if (mismatches == 0 && frame_results_due.size() == 0) begin
            $display("timestamp_ordered_frame_queue_top regression: pass");
        end else begin
            $display("timestamp_ordered_frame_queue_top regression: fail");
        end
        $finish;
    end

endmodule
